// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file of the pixel blender.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that is checked through reset as well.
`define ASSERT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/kapb_pkg.sv =====
// ----------------------------------------------------------------------------
// kapb_pkg
// Types and constants shared by the keyed additive pixel blender.
// ----------------------------------------------------------------------------
package kapb_pkg;

   localparam int CHAN_W         = 8;
   localparam int ALPHA_W        = 9;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 32;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [CHAN_W-1:0]  CHAN_MAX  = 8'hff;
   localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] REG_BLEND_ALPHA = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BLEND_MODE  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_ENABLE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_RED     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_GREEN   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_BLUE    = 3'd5;

   localparam logic MODE_NORMAL   = 1'b0;
   localparam logic MODE_ADDITIVE = 1'b1;

   typedef struct packed {
      logic [CHAN_W-1:0] src_red;
      logic [CHAN_W-1:0] src_green;
      logic [CHAN_W-1:0] src_blue;
      logic [CHAN_W-1:0] dst_red;
      logic [CHAN_W-1:0] dst_green;
      logic [CHAN_W-1:0] dst_blue;
   } req_word_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_red;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_blue;
      logic              write_enable;
   } rsp_word_type;

   // Settings seen by the front and back parts.
   typedef struct packed {
      logic [ALPHA_W-1:0]     alpha;
      logic                   mode;
      logic                   key_enable;
      logic [2:0][CHAN_W-1:0] key;
   } cfg_type;

   // Classified pixel waiting in the queue; index 0 is red, 2 is blue.
   typedef struct packed {
      logic                   keyed;
      logic [2:0][CHAN_W-1:0] src;
      logic [2:0][CHAN_W-1:0] dst;
   } queue_word_type;

endpackage

// ===== src/kapb_csr.sv =====
// ----------------------------------------------------------------------------
// kapb_csr
// Configuration registers of the blender, written through the csr channel.
// ----------------------------------------------------------------------------
module kapb_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [kapb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [kapb_pkg::CSR_DATA_W-1:0]  csr_data,
   output kapb_pkg::cfg_type               cfg
);
   import kapb_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_BLEND_ALPHA: cfg_in.alpha      = csr_data[ALPHA_W-1:0];
            REG_BLEND_MODE:  cfg_in.mode       = csr_data[0];
            REG_KEY_ENABLE:  cfg_in.key_enable = csr_data[0];
            REG_KEY_RED:     cfg_in.key[0]     = csr_data[CHAN_W-1:0];
            REG_KEY_GREEN:   cfg_in.key[1]     = csr_data[CHAN_W-1:0];
            REG_KEY_BLUE:    cfg_in.key[2]     = csr_data[CHAN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alpha      <= ALPHA_ONE;
         cfg_ff.mode       <= MODE_NORMAL;
         cfg_ff.key_enable <= 1'b0;
         cfg_ff.key        <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== src/kapb_front.sv =====
// ----------------------------------------------------------------------------
// kapb_front
// Accepts request words, checks them against the key color and hands
// them to the queue.
// ----------------------------------------------------------------------------
module kapb_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  kapb_pkg::req_word_type    req_word,
   input  kapb_pkg::cfg_type         cfg,
   output logic                      push,
   output kapb_pkg::queue_word_type  push_word,
   input  logic                      queue_full
);
   import kapb_pkg::*;

   logic           valid_ff, valid_in;
   queue_word_type word_ff, word_in;
   logic           accept;

   assign req_stall = valid_ff && queue_full;
   assign accept    = req_valid && !req_stall;
   assign push      = valid_ff && !queue_full;
   assign push_word = word_ff;
   assign valid_in  = accept || (valid_ff && queue_full);

   always_comb begin
      word_in.src   = {req_word.src_blue, req_word.src_green, req_word.src_red};
      word_in.dst   = {req_word.dst_blue, req_word.dst_green, req_word.dst_red};
      word_in.keyed = cfg.key_enable && (word_in.src == cfg.key);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= word_in;
      end
   end

endmodule

// ===== src/kapb_fifo.sv =====
// ----------------------------------------------------------------------------
// kapb_fifo
// Short queue between the front and back parts of the blender.
// ----------------------------------------------------------------------------
module kapb_fifo #(
   parameter int DEPTH = kapb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  kapb_pkg::queue_word_type  push_word,
   output logic                      full,
   input  logic                      pop,
   output kapb_pkg::queue_word_type  pop_word,
   output logic                      empty
);
   import kapb_pkg::*;

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   queue_word_type           entry_ff [DEPTH];
   logic [PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic                     do_push, do_pop;

   assign full     = (count_ff == COUNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_word = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ===== src/kapb_back.sv =====
// ----------------------------------------------------------------------------
// kapb_back
// Blend pipeline: scale by alpha, then either truncate and saturate (normal
// mode) or square, divide, add and clamp (additive mode), ending in the response register.
// ----------------------------------------------------------------------------
module kapb_back (
   input  logic                      clock,
   input  logic                      reset,
   input  kapb_pkg::cfg_type         cfg,
   output logic                      pop,
   input  kapb_pkg::queue_word_type  pop_word,
   input  logic                      queue_empty,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output kapb_pkg::rsp_word_type    rsp_word
);
   import kapb_pkg::*;

   localparam int PROD_W = CHAN_W + ALPHA_W;      // s * alpha
   localparam int SQ_W   = 2 * PROD_W;            // (s * alpha)^2
   localparam int Q_W    = SQ_W - 2 * CHAN_W;     // square without its 16 fraction bits
   localparam logic [Q_W-1:0] SAT_LIMIT = Q_W'(int'(CHAN_MAX) * int'(CHAN_MAX));

   // Additive channel: min(255, floor(q / 255) + dst). Below the limit q fits
   // 16 bits, where (x + (x >> 8) + 1) >> 8 is an exact divide by 255.
   function automatic logic [CHAN_W-1:0] add_chan(input logic [Q_W-1:0]    q,
                                                  input logic [CHAN_W-1:0] dst);
      logic [2*CHAN_W:0]   sum;
      logic [CHAN_W:0]     tot;
      logic [CHAN_W-1:0]   res;
      sum = (2*CHAN_W+1)'(q[2*CHAN_W-1:0]) + (2*CHAN_W+1)'(q[2*CHAN_W-1:CHAN_W])
            + (2*CHAN_W+1)'(1);
      tot = {1'b0, sum[2*CHAN_W-1:CHAN_W]} + {1'b0, dst};
      if (q >= SAT_LIMIT || tot[CHAN_W]) begin
         res = CHAN_MAX;
      end else begin
         res = tot[CHAN_W-1:0];
      end
      return res;
   endfunction

   logic                   advance;

   logic                   s1_valid_ff;
   logic                   s1_keyed_ff;
   logic [2:0][CHAN_W-1:0] s1_dst_ff;
   logic [2:0][PROD_W-1:0] s1_prod_ff, s1_prod_in;

   logic                   s2_valid_ff;
   logic                   s2_keyed_ff;
   logic [2:0][CHAN_W-1:0] s2_dst_ff;
   logic [2:0][Q_W-1:0]    s2_q_ff, s2_q_in;
   logic [2:0][CHAN_W-1:0] s2_norm_ff, s2_norm_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_word_type           rsp_word_ff, rsp_word_in;

   // The whole pipeline moves when the response register is free or drained.
   assign advance      = !rsp_valid_ff || !rsp_stall;
   assign pop          = advance && !queue_empty;
   assign rsp_valid_in = advance ? s2_valid_ff : rsp_valid_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_word     = rsp_word_ff;

   always_comb begin
      logic [SQ_W-1:0] sq;
      logic [2:0][CHAN_W-1:0] chan;
      sq = '0;
      for (int c = 0; c < 3; c++) begin
         s1_prod_in[c] = PROD_W'(pop_word.src[c]) * PROD_W'(cfg.alpha);
         sq            = SQ_W'(s1_prod_ff[c]) * SQ_W'(s1_prod_ff[c]);
         s2_q_in[c]    = sq[SQ_W-1:2*CHAN_W];
         s2_norm_in[c] = s1_prod_ff[c][PROD_W-1] ? CHAN_MAX
                                                 : s1_prod_ff[c][PROD_W-2:CHAN_W];
      end
      for (int c = 0; c < 3; c++) begin
         if (s2_keyed_ff) begin
            chan[c] = s2_dst_ff[c];
         end else if (cfg.mode == MODE_ADDITIVE) begin
            chan[c] = add_chan(s2_q_ff[c], s2_dst_ff[c]);
         end else begin
            chan[c] = s2_norm_ff[c];
         end
      end
      rsp_word_in.out_red      = chan[0];
      rsp_word_in.out_green    = chan[1];
      rsp_word_in.out_blue     = chan[2];
      rsp_word_in.write_enable = !s2_keyed_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            s1_valid_ff <= pop;
            s2_valid_ff <= s1_valid_ff;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_keyed_ff <= pop_word.keyed;
         s1_dst_ff   <= pop_word.dst;
         s1_prod_ff  <= s1_prod_in;
         s2_keyed_ff <= s1_keyed_ff;
         s2_dst_ff   <= s1_dst_ff;
         s2_q_ff     <= s2_q_in;
         s2_norm_ff  <= s2_norm_in;
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule

// ===== src/keyed_additive_pixel_blend_core.sv =====
// ----------------------------------------------------------------------------
// keyed_additive_pixel_blend_core
// Color-keyed scaled copy and additive blend of RGB24 pixels.
// ----------------------------------------------------------------------------
// Each request word carries a source pixel and the destination pixel under it;
// each one produces exactly one response word, in order. Normal mode gives
// trunc(src * alpha), saturated; additive mode gives
// min(255, floor((src * alpha)^2 / 255) + dst). A source pixel equal to the key
// color, with keying on, returns the destination with write_enable low.
// Both data channels use valid and stall; a word moves when valid is high and
// stall is low. The csr channel (valid/ready, always ready) sets alpha, mode
// and key; it must be written only while no pixel is in flight, which the
// block does not enforce. Throughput is one word per clock while rsp_stall
// is low. From acceptance a word passes the front register, the queue, the
// multiply stage and the square stage, with divide, add and clamp before
// the output register. A response stall freezes the back pipeline; the
// queue and front register keep taking words until the queue fills, then
// req_stall rises. Synchronous reset empties the pipeline and queue and
// loads alpha with one, normal mode and keying off. No clearing pass is needed.
// ----------------------------------------------------------------------------
module keyed_additive_pixel_blend_core #(
   parameter int QUEUE_DEPTH = kapb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  kapb_pkg::req_word_type           req_word,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output kapb_pkg::rsp_word_type           rsp_word,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [kapb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [kapb_pkg::CSR_DATA_W-1:0]  csr_data
);
   import kapb_pkg::*;

   cfg_type        cfg;
   logic           push, pop, queue_full, queue_empty;
   queue_word_type push_word, pop_word;

   kapb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   kapb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .cfg        (cfg),
      .push       (push),
      .push_word  (push_word),
      .queue_full (queue_full)
   );

   kapb_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .full      (queue_full),
      .pop       (pop),
      .pop_word  (pop_word),
      .empty     (queue_empty)
   );

   kapb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .pop         (pop),
      .pop_word    (pop_word),
      .queue_empty (queue_empty),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word)
   );

endmodule

// ===== src/kapb_checker.sv =====
// ----------------------------------------------------------------------------
// kapb_checker
// Port-level checks of the pixel blender, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kapb_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input kapb_pkg::rsp_word_type rsp_word
);
   import kapb_pkg::*;

   // Words accepted but not yet delivered.
   logic [4:0] open_ff, open_in;
   logic       req_take, rsp_take;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   always_comb begin
      open_in = open_ff;
      if (req_take && !rsp_take) begin
         open_in = open_ff + 1'b1;
      end else if (rsp_take && !req_take) begin
         open_in = open_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word))
   `ASSERT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)
   `ASSERT_IMPLIES(a_no_invented, clock, reset, rsp_valid, open_ff != '0)
   `ASSERT_IMPLIES(a_idle_ready, clock, reset, open_ff == '0, !req_stall)

endmodule

bind keyed_additive_pixel_blend_core kapb_checker u_kapb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
